>>> sv/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Types and constants shared by the buffer free-list allocator modules.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int SIZE_W    = 17;
    localparam int OFS_W     = 26;
    localparam int TOT_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0]  CNT_RESET  = 11'd1024;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd2048;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 17'd65536;

    localparam logic FUNC_ACQUIRE = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUFFER_COUNT = 2'd0,
        CFG_BUFFER_SIZE  = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic             func;
        logic [IDX_W-1:0] release_index;
    } t_req;

    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] buffer_index;
        logic [OFS_W-1:0] byte_offset;
        logic             exhausted;
        logic             bad_release;
        logic [CNT_W-1:0] free_count;
        logic [TOT_W-1:0] acquire_total;
        logic [TOT_W-1:0] release_total;
        logic [TOT_W-1:0] exhausted_total;
    } t_rsp;

endpackage

>>> sv/bfa_link_ram.sv
// ----------------------------------------------------------------------------
// bfa_link_ram
// Next-link memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfa_link_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [AW-1:0] o_rdata
);

    logic [AW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bfa_stack.sv
// ----------------------------------------------------------------------------
// bfa_stack
// Free stack control: top and prefetched next link, level, counters,
// configuration registers and the link memory rebuild sweep.
// ----------------------------------------------------------------------------
module bfa_stack #(
    parameter int POOL_DEPTH = 1024,
    parameter int IW         = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bfa_pkg::SIZE_W-1:0]     i_cfg_data,
    input  logic                           i_fire,
    input  bfa_pkg::t_req                  i_req,
    output logic                           o_busy,
    output bfa_pkg::t_rsp                  o_rsp,
    output logic                           o_ram_we,
    output logic [IW-1:0]                  o_ram_waddr,
    output logic [IW-1:0]                  o_ram_wdata,
    output logic [IW-1:0]                  o_ram_raddr,
    input  logic [IW-1:0]                  i_ram_rdata
);

    localparam int LW = $clog2(POOL_DEPTH + 1);
    localparam int UW = (LW > bfa_pkg::CNT_W) ? LW : bfa_pkg::CNT_W;
    localparam int PW = IW + bfa_pkg::SIZE_W;

    function automatic logic [UW-1:0] f_used(input logic [bfa_pkg::CNT_W-1:0] c);
        logic [UW-1:0] v;
        v = UW'(c);
        if (v == '0) begin
            f_used = UW'(1);
        end else if (v > UW'(POOL_DEPTH)) begin
            f_used = UW'(POOL_DEPTH);
        end else begin
            f_used = v;
        end
    endfunction

    logic [IW-1:0]                r_top, n_top;
    logic [IW-1:0]                r_next, n_next;
    logic                         r_pend, n_pend;
    logic [LW-1:0]                r_level, n_level;
    logic [bfa_pkg::TOT_W-1:0]    r_acq, n_acq;
    logic [bfa_pkg::TOT_W-1:0]    r_rel, n_rel;
    logic [bfa_pkg::TOT_W-1:0]    r_exh, n_exh;
    logic [bfa_pkg::CNT_W-1:0]    r_count, n_count;
    logic [bfa_pkg::SIZE_W-1:0]   r_size, n_size;
    logic                         r_sweep, n_sweep;
    logic [IW-1:0]                r_sidx, n_sidx;

    logic [UW-1:0]                used_cnt;
    logic [UW-1:0]                new_used;
    logic [bfa_pkg::SIZE_W-1:0]   used_size;
    logic [IW-1:0]                eff_next;
    logic [IW-1:0]                rel_idx;
    logic [PW-1:0]                product;
    logic                         is_acq;
    logic                         is_rel;
    logic                         rel_ok;
    logic                         granted;
    logic                         cfg_hit;

    assign used_cnt  = f_used(r_count);
    assign used_size = (r_size == '0) ? bfa_pkg::SIZE_W'(1) :
                       (r_size > bfa_pkg::SIZE_MAX) ? bfa_pkg::SIZE_MAX : r_size;
    assign eff_next  = r_pend ? i_ram_rdata : r_next;
    assign rel_idx   = IW'(i_req.release_index);
    assign is_acq    = i_fire && (i_req.func == bfa_pkg::FUNC_ACQUIRE);
    assign is_rel    = i_fire && (i_req.func == bfa_pkg::FUNC_RELEASE);
    assign rel_ok    = UW'(i_req.release_index) < used_cnt;
    assign granted   = is_acq && (r_level != '0);
    assign product   = PW'(r_top) * PW'(used_size);
    assign cfg_hit   = i_cfg_valid &&
                       (i_cfg_index inside {bfa_pkg::CFG_BUFFER_COUNT, bfa_pkg::CFG_BUFFER_SIZE});

    always_comb begin
        n_count = r_count;
        n_size  = r_size;
        if (i_cfg_valid && (i_cfg_index == bfa_pkg::CFG_BUFFER_COUNT)) begin
            n_count = i_cfg_data[bfa_pkg::CNT_W-1:0];
        end
        if (i_cfg_valid && (i_cfg_index == bfa_pkg::CFG_BUFFER_SIZE)) begin
            n_size = i_cfg_data;
        end
    end

    assign new_used = f_used(n_count);

    always_comb begin
        n_top       = r_top;
        n_next      = eff_next;
        n_pend      = 1'b0;
        n_level     = r_level;
        n_acq       = r_acq;
        n_rel       = r_rel;
        n_exh       = r_exh;
        n_sweep     = r_sweep;
        n_sidx      = r_sidx;
        o_ram_we    = 1'b0;
        o_ram_waddr = rel_idx;
        o_ram_wdata = r_top;

        if (granted) begin
            n_top   = eff_next;
            n_next  = r_next;
            n_pend  = 1'b1;
            n_level = r_level - LW'(1);
            n_acq   = r_acq + bfa_pkg::TOT_W'(1);
        end else if (is_acq) begin
            n_exh = r_exh + bfa_pkg::TOT_W'(1);
        end else if (is_rel && rel_ok) begin
            o_ram_we = 1'b1;
            n_top    = rel_idx;
            n_next   = r_top;
            n_rel    = r_rel + bfa_pkg::TOT_W'(1);
            if (r_level < LW'(POOL_DEPTH)) begin
                n_level = r_level + LW'(1);
            end
        end

        if (r_sweep) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = r_sidx;
            o_ram_wdata = (r_sidx == '0) ? '0 : r_sidx - IW'(1);
            n_sidx      = r_sidx + IW'(1);
            if (r_sidx == IW'(POOL_DEPTH - 1)) begin
                n_sweep = 1'b0;
            end
        end

        if (cfg_hit) begin
            n_top   = IW'(new_used - UW'(1));
            n_next  = (new_used >= UW'(2)) ? IW'(new_used - UW'(2)) : '0;
            n_pend  = 1'b0;
            n_level = LW'(new_used);
            n_sweep = 1'b1;
            n_sidx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= bfa_pkg::CNT_RESET;
            r_size  <= bfa_pkg::SIZE_RESET;
            r_top   <= IW'(f_used(bfa_pkg::CNT_RESET) - UW'(1));
            r_next  <= IW'(f_used(bfa_pkg::CNT_RESET) - UW'(2));
            r_pend  <= 1'b0;
            r_level <= LW'(f_used(bfa_pkg::CNT_RESET));
            r_acq   <= '0;
            r_rel   <= '0;
            r_exh   <= '0;
            r_sweep <= 1'b1;
            r_sidx  <= '0;
        end else begin
            r_count <= n_count;
            r_size  <= n_size;
            r_top   <= n_top;
            r_next  <= n_next;
            r_pend  <= n_pend;
            r_level <= n_level;
            r_acq   <= n_acq;
            r_rel   <= n_rel;
            r_exh   <= n_exh;
            r_sweep <= n_sweep;
            r_sidx  <= n_sidx;
        end
    end

    // pop fetches the link of the new top; used in the following cycle via r_pend
    assign o_ram_raddr = eff_next;
    assign o_busy      = r_sweep;

    always_comb begin
        o_rsp                 = '0;
        o_rsp.granted         = granted;
        o_rsp.buffer_index    = granted ? bfa_pkg::IDX_W'(r_top) : '0;
        o_rsp.byte_offset     = granted ? bfa_pkg::OFS_W'(product) : '0;
        o_rsp.exhausted       = is_acq && !granted;
        o_rsp.bad_release     = is_rel && !rel_ok;
        o_rsp.free_count      = bfa_pkg::CNT_W'(n_level);
        o_rsp.acquire_total   = n_acq;
        o_rsp.release_total   = n_rel;
        o_rsp.exhausted_total = n_exh;
    end

endmodule

>>> sv/bfa_out_buf.sv
// ----------------------------------------------------------------------------
// bfa_out_buf
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module bfa_out_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  bfa_pkg::t_rsp i_rsp,
    output logic          o_valid,
    input  logic          i_ready,
    output bfa_pkg::t_rsp o_rsp,
    output logic          o_full
);

    logic          r_ov, n_ov;
    logic          r_sv, n_sv;
    bfa_pkg::t_rsp r_od, n_od;
    bfa_pkg::t_rsp r_sd, n_sd;
    logic          take;

    assign take = r_ov && i_ready;

    always_comb begin
        n_ov = r_ov;
        n_sv = r_sv;
        n_od = r_od;
        n_sd = r_sd;
        if (r_sv) begin
            if (take) begin
                n_od = r_sd;
                n_sv = 1'b0;
            end
        end else if (i_load) begin
            if (!r_ov || take) begin
                n_od = i_rsp;
                n_ov = 1'b1;
            end else begin
                n_sd = i_rsp;
                n_sv = 1'b1;
            end
        end else if (take) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_od <= n_od;
        r_sd <= n_sd;
    end

    assign o_valid = r_ov;
    assign o_rsp   = r_od;
    assign o_full  = r_sv;

endmodule

>>> sv/buffer_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// buffer_free_list_allocator_unit
// Buffer pool allocator built on a LIFO free stack with a next-link memory.
// ----------------------------------------------------------------------------
// Request channel (i_req_valid/o_req_ready, i_req): func acquire pops the top
// free index and returns it with its byte offset; func release pushes an
// index back. Every item gives exactly one response item on the response
// channel (o_rsp_valid/i_rsp_ready, o_rsp), with level and running totals.
// Configuration channel (i_cfg_valid/o_cfg_ready): index 0 buffer count,
// index 1 buffer size; each write to either rebuilds the pool. Always ready.
// The response is registered in the result register, or in the skid entry
// while the receiver stalls. Throughput: one item per cycle while
// o_req_ready is high. The top's next link is held prefetched; a pop reads
// the new top's link from the link memory, and that registered read feeds
// the following item directly. Reset and each write to index 0 or 1 start a
// pass that rewrites every link memory entry; o_req_ready stays low during it.
// A stalled receiver is absorbed by a result register plus one skid entry;
// o_req_ready otherwise drops only while the skid entry is occupied.
// ----------------------------------------------------------------------------
module buffer_free_list_allocator_unit #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  bfa_pkg::t_req                  i_req,
    output logic                           o_rsp_valid,
    input  logic                           i_rsp_ready,
    output bfa_pkg::t_rsp                  o_rsp,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bfa_pkg::SIZE_W-1:0]     i_cfg_data
);

    localparam int IW = $clog2(POOL_DEPTH);

    logic          fire;
    logic          busy;
    logic          full;
    bfa_pkg::t_rsp rsp;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [IW-1:0] ram_rdata;

    assign o_req_ready = !busy && !full;
    assign fire        = i_req_valid && o_req_ready;
    assign o_cfg_ready = 1'b1;

    bfa_stack #(
        .POOL_DEPTH (POOL_DEPTH),
        .IW         (IW)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_req       (i_req),
        .o_busy      (busy),
        .o_rsp       (rsp),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    bfa_link_ram #(
        .DEPTH (POOL_DEPTH),
        .AW    (IW)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bfa_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_rsp   (rsp),
        .o_valid (o_rsp_valid),
        .i_ready (i_rsp_ready),
        .o_rsp   (o_rsp),
        .o_full  (full)
    );

endmodule

>>> sv/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks on the allocator response channel.
// ----------------------------------------------------------------------------
module bfa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_rsp_valid,
    input logic          i_rsp_ready,
    input bfa_pkg::t_rsp o_rsp
);

    a_grant_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.granted && (o_rsp.exhausted || o_rsp.bad_release)))
        else $error("grant together with exhausted or bad release");

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.granted) |->
            (o_rsp.buffer_index == '0) && (o_rsp.byte_offset == '0))
        else $error("index or offset set without a grant");

    a_exh_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.exhausted) |-> (o_rsp.free_count == '0))
        else $error("exhausted with free buffers left");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_ready) |=> (o_rsp_valid && $stable(o_rsp)))
        else $error("stalled response item changed");

endmodule

bind buffer_free_list_allocator_unit bfa_checker u_bfa_checker (.*);

>>> tb/sv/buffer_free_list_allocator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buffer_free_list_allocator_unit_tb
// Self-checking bench for the free-stack buffer allocator. A directed table
// covers reset values, register extremes, exhaustion, bad and double release;
// random phases then reprogram the pool and mix acquires with releases of
// held, double and out-of-range indices. Every response item is checked
// field by field against its table entry or an in-bench free-stack predictor.
// ----------------------------------------------------------------------------
module buffer_free_list_allocator_unit_tb;

    localparam int POOL_DEPTH     = 1024;
    localparam int RANDOM_ITEMS   = 900;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int DIR_LEN        = 34;

    localparam logic [bfa_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [bfa_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_ITEM,
        STEP_CHECK
    } t_step_kind;

    typedef struct packed {
        t_step_kind                        kind;
        logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_index;
        logic [bfa_pkg::SIZE_W-1:0]        cfg_data;
        bfa_pkg::t_req                     req;
        bfa_pkg::t_rsp                     rsp;
    } t_dir_step;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_req_valid = 1'b0;
    logic                          o_req_ready;
    bfa_pkg::t_req                 i_req       = '0;
    logic                          o_rsp_valid;
    logic                          i_rsp_ready = 1'b0;
    bfa_pkg::t_rsp                 o_rsp;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [bfa_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [bfa_pkg::SIZE_W-1:0]    i_cfg_data  = '0;

    // free-stack predictor state
    logic [bfa_pkg::IDX_W-1:0]  fs_link [POOL_DEPTH];
    logic [bfa_pkg::IDX_W-1:0]  fs_top;
    logic [bfa_pkg::CNT_W-1:0]  fs_level;
    logic [bfa_pkg::TOT_W-1:0]  acq_total;
    logic [bfa_pkg::TOT_W-1:0]  rel_total;
    logic [bfa_pkg::TOT_W-1:0]  exh_total;
    logic [bfa_pkg::CNT_W-1:0]  reg_count;
    logic [bfa_pkg::SIZE_W-1:0] reg_size;

    bfa_pkg::t_rsp              pending_rsp_q [$];
    logic [bfa_pkg::IDX_W-1:0]  held_q [$];
    int                         err_count   = 0;
    int                         rsp_seen    = 0;
    int                         burst_left  = 0;
    int                         rsp_hold    = 0;
    int                         idle_cycles = 0;

    t_dir_step dir_steps [DIR_LEN] = '{
        '{STEP_CHECK, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_ACQUIRE, 10'h3FF},
          '{1'b1, 10'd1023, 26'd2095104, 1'b0, 1'b0, 11'd1023, 32'd1, 32'd0, 32'd0}},
        '{STEP_CHECK, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_RELEASE, 10'd1023},
          '{1'b0, 10'd0, 26'd0, 1'b0, 1'b0, 11'd1024, 32'd1, 32'd1, 32'd0}},
        '{STEP_CHECK, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_RELEASE, 10'd0},
          '{1'b0, 10'd0, 26'd0, 1'b0, 1'b0, 11'd1024, 32'd1, 32'd2, 32'd0}},
        '{STEP_CHECK, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_ACQUIRE, 10'd0},
          '{1'b1, 10'd0, 26'd0, 1'b0, 1'b0, 11'd1023, 32'd2, 32'd2, 32'd0}},
        '{STEP_CFG, bfa_pkg::CFG_BUFFER_COUNT, 17'd1, '0, '0},
        '{STEP_CFG, bfa_pkg::CFG_BUFFER_SIZE, 17'd65536, '0, '0},
        '{STEP_CHECK, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_ACQUIRE, 10'h2AA},
          '{1'b1, 10'd0, 26'd0, 1'b0, 1'b0, 11'd0, 32'd3, 32'd2, 32'd0}},
        '{STEP_CHECK, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_ACQUIRE, 10'd0},
          '{1'b0, 10'd0, 26'd0, 1'b1, 1'b0, 11'd0, 32'd3, 32'd2, 32'd1}},
        '{STEP_CHECK, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_RELEASE, 10'd1},
          '{1'b0, 10'd0, 26'd0, 1'b0, 1'b1, 11'd0, 32'd3, 32'd2, 32'd1}},
        '{STEP_CHECK, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_RELEASE, 10'd1023},
          '{1'b0, 10'd0, 26'd0, 1'b0, 1'b1, 11'd0, 32'd3, 32'd2, 32'd1}},
        '{STEP_CHECK, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_RELEASE, 10'd0},
          '{1'b0, 10'd0, 26'd0, 1'b0, 1'b0, 11'd1, 32'd3, 32'd3, 32'd1}},
        '{STEP_CFG, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '0, '0},
        '{STEP_CHECK, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_ACQUIRE, 10'h155},
          '{1'b1, 10'd0, 26'd0, 1'b0, 1'b0, 11'd0, 32'd4, 32'd3, 32'd1}},
        '{STEP_CHECK, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_RELEASE, 10'h155},
          '{1'b0, 10'd0, 26'd0, 1'b0, 1'b1, 11'd0, 32'd4, 32'd3, 32'd1}},
        '{STEP_CFG, bfa_pkg::CFG_BUFFER_COUNT, 17'h1FFFF, '0, '0},
        '{STEP_CFG, bfa_pkg::CFG_BUFFER_SIZE, 17'h1FFFF, '0, '0},
        '{STEP_CHECK, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_ACQUIRE, 10'd0},
          '{1'b1, 10'd1023, 26'd67043328, 1'b0, 1'b0, 11'd1023, 32'd5, 32'd3, 32'd1}},
        '{STEP_CFG, bfa_pkg::CFG_BUFFER_SIZE, 17'd0, '0, '0},
        '{STEP_CHECK, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_ACQUIRE, 10'd0},
          '{1'b1, 10'd1023, 26'd1023, 1'b0, 1'b0, 11'd1023, 32'd6, 32'd3, 32'd1}},
        '{STEP_CFG, CFG_SPARE_A, 17'd5, '0, '0},
        '{STEP_CFG, CFG_SPARE_B, 17'h1FFFF, '0, '0},
        '{STEP_CHECK, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_ACQUIRE, 10'd0},
          '{1'b1, 10'd1022, 26'd1022, 1'b0, 1'b0, 11'd1022, 32'd7, 32'd3, 32'd1}},
        '{STEP_CFG, bfa_pkg::CFG_BUFFER_SIZE, 17'd3, '0, '0},
        '{STEP_CFG, bfa_pkg::CFG_BUFFER_COUNT, 17'd3, '0, '0},
        '{STEP_ITEM, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_ACQUIRE, 10'd0}, '0},
        '{STEP_ITEM, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_ACQUIRE, 10'd0}, '0},
        '{STEP_ITEM, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_RELEASE, 10'd2}, '0},
        '{STEP_ITEM, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_ACQUIRE, 10'd0}, '0},
        '{STEP_ITEM, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_ACQUIRE, 10'd0}, '0},
        '{STEP_ITEM, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_ACQUIRE, 10'd0}, '0},
        '{STEP_ITEM, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_RELEASE, 10'd3}, '0},
        '{STEP_ITEM, bfa_pkg::CFG_BUFFER_COUNT, 17'd0, '{bfa_pkg::FUNC_RELEASE, 10'h3FF}, '0},
        '{STEP_CFG, bfa_pkg::CFG_BUFFER_COUNT, 17'd1024, '0, '0},
        '{STEP_CFG, bfa_pkg::CFG_BUFFER_SIZE, 17'd2048, '0, '0}
    };

    buffer_free_list_allocator_unit #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int eff_count();
        if (reg_count == '0) return 1;
        if (int'(reg_count) > POOL_DEPTH) return POOL_DEPTH;
        return int'(reg_count);
    endfunction

    function automatic logic [bfa_pkg::SIZE_W-1:0] eff_size();
        if (reg_size == '0) return bfa_pkg::SIZE_W'(1);
        if (reg_size > bfa_pkg::SIZE_MAX) return bfa_pkg::SIZE_MAX;
        return reg_size;
    endfunction

    function automatic void free_stack_rebuild();
        int n;
        n = eff_count();
        for (int i = 0; i < POOL_DEPTH; i++) begin
            fs_link[i] = (i == 0) ? '0 : bfa_pkg::IDX_W'(i - 1);
        end
        fs_top   = bfa_pkg::IDX_W'(n - 1);
        fs_level = bfa_pkg::CNT_W'(n);
    endfunction

    function automatic bfa_pkg::t_rsp free_stack_step(input bfa_pkg::t_req req);
        bfa_pkg::t_rsp r;
        logic [63:0]   product;
        r = '0;
        if (req.func == bfa_pkg::FUNC_ACQUIRE) begin
            if (fs_level == '0) begin
                r.exhausted = 1'b1;
                exh_total++;
            end else begin
                r.granted      = 1'b1;
                r.buffer_index = fs_top;
                product        = 64'(fs_top) * 64'(eff_size());
                r.byte_offset  = product[bfa_pkg::OFS_W-1:0];
                fs_top         = fs_link[fs_top];
                fs_level--;
                acq_total++;
            end
        end else if (int'(req.release_index) >= eff_count()) begin
            r.bad_release = 1'b1;
        end else begin
            fs_link[req.release_index] = fs_top;
            fs_top = req.release_index;
            if (fs_level < bfa_pkg::CNT_W'(POOL_DEPTH)) fs_level++;
            rel_total++;
        end
        r.free_count      = fs_level;
        r.acquire_total   = acq_total;
        r.release_total   = rel_total;
        r.exhausted_total = exh_total;
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [bfa_pkg::TOT_W-1:0] exp_v,
                               input logic [bfa_pkg::TOT_W-1:0] act_v);
        if (act_v !== exp_v) begin
            note_mismatch($sformatf("item %0d %s expected %0d got %0d",
                                    rsp_seen, name, exp_v, act_v));
        end
    endtask

    // at most one nonblocking write to i_req_valid per edge: only lowered here
    // when results are still pending, which guarantees the task waits on the clock
    task automatic drain_results();
        if (pending_rsp_q.size() != 0) begin
            i_req_valid <= 1'b0;
            while (pending_rsp_q.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [bfa_pkg::CFG_IDX_W-1:0] index,
                             input logic [bfa_pkg::SIZE_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            bfa_pkg::CFG_BUFFER_COUNT: begin
                reg_count = data[bfa_pkg::CNT_W-1:0];
                free_stack_rebuild();
            end
            bfa_pkg::CFG_BUFFER_SIZE: begin
                reg_size = data;
                free_stack_rebuild();
            end
            default: ;
        endcase
    endtask

    // config channel is dropped once items flow again
    task automatic send_req(input bfa_pkg::t_req req, input logic use_table,
                            input bfa_pkg::t_rsp table_rsp, output bfa_pkg::t_rsp predicted);
        i_req_valid <= 1'b1;
        i_req       <= req;
        i_cfg_valid <= 1'b0;
        do @(posedge i_clk); while (!o_req_ready);
        predicted = free_stack_step(req);
        pending_rsp_q.push_back(use_table ? table_rsp : predicted);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    always @(posedge i_clk) begin
        if (rsp_hold != 0) begin
            rsp_hold <= rsp_hold - 1;
        end else begin
            case ($urandom_range(0, 9))
                0: begin
                    i_rsp_ready <= 1'b0;
                    rsp_hold    <= $urandom_range(1, 24);
                end
                1, 2: begin
                    i_rsp_ready <= 1'b0;
                    rsp_hold    <= 0;
                end
                default: begin
                    i_rsp_ready <= 1'b1;
                    rsp_hold    <= $urandom_range(0, 40);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        bfa_pkg::t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (pending_rsp_q.size() == 0) begin
                note_mismatch($sformatf("response item %0d with none pending", rsp_seen));
            end else begin
                want = pending_rsp_q.pop_front();
                check_field("granted", bfa_pkg::TOT_W'(want.granted),
                            bfa_pkg::TOT_W'(o_rsp.granted));
                check_field("buffer_index", bfa_pkg::TOT_W'(want.buffer_index),
                            bfa_pkg::TOT_W'(o_rsp.buffer_index));
                check_field("byte_offset", bfa_pkg::TOT_W'(want.byte_offset),
                            bfa_pkg::TOT_W'(o_rsp.byte_offset));
                check_field("exhausted", bfa_pkg::TOT_W'(want.exhausted),
                            bfa_pkg::TOT_W'(o_rsp.exhausted));
                check_field("bad_release", bfa_pkg::TOT_W'(want.bad_release),
                            bfa_pkg::TOT_W'(o_rsp.bad_release));
                check_field("free_count", bfa_pkg::TOT_W'(want.free_count),
                            bfa_pkg::TOT_W'(o_rsp.free_count));
                check_field("acquire_total", want.acquire_total, o_rsp.acquire_total);
                check_field("release_total", want.release_total, o_rsp.release_total);
                check_field("exhausted_total", want.exhausted_total, o_rsp.exhausted_total);
            end
            rsp_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        bfa_pkg::t_rsp             rsp;
        bfa_pkg::t_req             req;
        int                        items_sent;
        int                        acq_pct;
        int                        phase_len;
        int                        cnt;
        int                        sz;
        int                        pick;
        int                        pos;
        logic [bfa_pkg::IDX_W-1:0] rel_idx;

        items_sent = 0;
        reg_count  = bfa_pkg::CNT_RESET;
        reg_size   = bfa_pkg::SIZE_RESET;
        acq_total  = '0;
        rel_total  = '0;
        exh_total  = '0;
        free_stack_rebuild();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_steps[i]) begin
            if (dir_steps[i].kind == STEP_CFG) begin
                write_reg(dir_steps[i].cfg_index, dir_steps[i].cfg_data);
            end else begin
                send_req(dir_steps[i].req, dir_steps[i].kind == STEP_CHECK,
                         dir_steps[i].rsp, rsp);
                pace_sender();
            end
        end

        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       cnt = 1;
                1:       cnt = POOL_DEPTH;
                2:       cnt = $urandom_range(POOL_DEPTH + 1, 2047);
                3:       cnt = 0;
                4:       cnt = $urandom_range(2, POOL_DEPTH - 1);
                5, 6:    cnt = $urandom_range(2, 64);
                default: cnt = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 7))
                0:       sz = 0;
                1:       sz = 1;
                2:       sz = 65536;
                3:       sz = $urandom_range(65537, 131071);
                default: sz = $urandom_range(0, 131071);
            endcase
            if ($urandom_range(0, 1) == 0) begin
                write_reg(bfa_pkg::CFG_BUFFER_COUNT,
                          {6'($urandom_range(0, 63)), bfa_pkg::CNT_W'(cnt)});
                write_reg(bfa_pkg::CFG_BUFFER_SIZE, bfa_pkg::SIZE_W'(sz));
            end else begin
                write_reg(bfa_pkg::CFG_BUFFER_SIZE, bfa_pkg::SIZE_W'(sz));
                write_reg(bfa_pkg::CFG_BUFFER_COUNT,
                          {6'($urandom_range(0, 63)), bfa_pkg::CNT_W'(cnt)});
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          bfa_pkg::SIZE_W'($urandom_range(0, 131071)));
            end
            held_q.delete();

            case ($urandom_range(0, 3))
                0:       acq_pct = 25;
                1:       acq_pct = 50;
                2:       acq_pct = 65;
                default: acq_pct = 80;
            endcase
            phase_len = $urandom_range(30, 90);

            repeat (phase_len) begin
                if ($urandom_range(0, 99) < acq_pct) begin
                    req.func          = bfa_pkg::FUNC_ACQUIRE;
                    req.release_index = bfa_pkg::IDX_W'($urandom_range(0, 1023));
                end else begin
                    pick = $urandom_range(0, 99);
                    if (held_q.size() != 0 && pick < 70) begin
                        pos     = $urandom_range(0, held_q.size() - 1);
                        rel_idx = held_q[pos];
                        held_q.delete(pos);
                    end else if (pick < 88) begin
                        rel_idx = bfa_pkg::IDX_W'($urandom_range(0, eff_count() - 1));
                    end else begin
                        rel_idx = bfa_pkg::IDX_W'($urandom_range(0, 1023));
                    end
                    req.func          = bfa_pkg::FUNC_RELEASE;
                    req.release_index = rel_idx;
                end
                send_req(req, 1'b0, '0, rsp);
                if (rsp.granted) held_q.push_back(rsp.buffer_index);
                items_sent++;
                if ($urandom_range(0, 63) == 0) begin
                    drain_results();
                end else begin
                    pace_sender();
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
